FILE: src/spfs_pkg.sv
// Shared types and constants for the smallest-prime-factor sieve unit.
// No dependencies; imported by spfs_div, the top level and the testbench.
package spfs_pkg;

    // Fixed port widths
    localparam int DATA_W     = 16;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    // Parameter defaults
    localparam int MAX_LIMIT_DEF   = 65535;
    localparam int PRIME_SLOTS_DEF = 8192;

    // Factor chain storage
    localparam int FACTOR_CAP = 16;
    localparam int NW         = $clog2(FACTOR_CAP + 1);
    localparam int CIW        = $clog2(FACTOR_CAP);

    // Divider step counter width
    localparam int DIV_CNT_W  = $clog2(DATA_W + 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SPF   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FACT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PRIME = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

FILE: src/spfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/spfs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on spfs_pkg (div_req_t, div_rsp_t, DATA_W).
module spfs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  spfs_pkg::div_req_t req,
    output spfs_pkg::div_rsp_t rsp
);
    import spfs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;
    logic                 fits;

    // Trial subtract of the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = !trial[DATA_W];

    // Load on start, then one step per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: src/smallest_prime_factor_sieve_unit.sv
// Smallest-prime-factor sieve unit: top level with sequencer, table and prime list.
// Depends on spfs_pkg, spfs_ram and spfs_div.
//
// Issue a command with start while busy is low. A build (command 0) first clears
// entries 0..L of the factor table (L = sieve_limit saturated at MAX_LIMIT),
// then walks the linear sieve with the one-step sequencer on a single table
// port: it reads each number, records it as a new prime or takes its known
// smallest factor, then marks i * p for each listed prime p up to that factor;
// it ends with one beat carrying the prime count. A factorization divides out
// each prime factor with the bit-serial divider, then emits its factors one
// beat per cycle, largest first, last high on the final beat. Result beats are
// shown for exactly one cycle on result_valid and cannot be held off. Write
// sieve_limit through the cfg channel only while the unit is idle.
module smallest_prime_factor_sieve_unit #(
    parameter int MAX_LIMIT   = spfs_pkg::MAX_LIMIT_DEF,
    parameter int PRIME_SLOTS = spfs_pkg::PRIME_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [spfs_pkg::CMD_W-1:0]     command,
    input  logic [spfs_pkg::DATA_W-1:0]    operand,
    output logic                           result_valid,
    output logic [spfs_pkg::STATUS_W-1:0]  status,
    output logic [spfs_pkg::DATA_W-1:0]    answer,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spfs_pkg::DATA_W-1:0]    cfg_data
);
    import spfs_pkg::*;

    localparam int LW  = $clog2(MAX_LIMIT + 1);
    localparam int IW  = LW + 1;
    localparam int MW  = 2 * LW;
    localparam int PAW = $clog2(PRIME_SLOTS);
    localparam int CW  = $clog2(PRIME_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SIEVE_RD, S_SIEVE_CHK, S_PRIME_RD, S_PRIME_MUL,
        S_MARK, S_FINISH, S_QUERY, S_FACT_RD, S_FACT_CHK, S_FACT_DIV,
        S_FACT_END, S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   sieve_limit_reg, sieve_limit_next;
    logic [LW-1:0]       built_reg, built_next;
    logic                valid_reg, valid_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [LW-1:0]       lim_reg, lim_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [LW-1:0]       spf_reg, spf_next;
    logic [LW-1:0]       p_reg, p_next;
    logic [MW-1:0]       m_reg, m_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [DATA_W-1:0]   x_reg, x_next;
    logic [DATA_W-1:0]   fp_reg, fp_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [NW-1:0]       e_reg, e_next;
    logic [DATA_W-1:0]   chain_reg [FACTOR_CAP];
    logic [DATA_W-1:0]   chain_next [FACTOR_CAP];
    logic                rv_reg, rv_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [DATA_W-1:0]   ans_reg, ans_next;
    logic                last_reg, last_next;

    logic                ft_we;
    logic [LW-1:0]       ft_waddr, ft_wdata, ft_raddr, ft_rdata;
    logic                pl_we;
    logic [PAW-1:0]      pl_waddr, pl_raddr;
    logic [LW-1:0]       pl_wdata, pl_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    logic [LW-1:0]       lim_sat;
    logic [DATA_W-1:0]   ft_word;
    logic [NW-1:0]       e_dec;

    // Factor table and prime list
    spfs_ram #(.WIDTH(LW), .DEPTH(MAX_LIMIT + 1)) u_factor_table (
        .clk(clk), .we(ft_we), .waddr(ft_waddr), .wdata(ft_wdata),
        .raddr(ft_raddr), .rdata(ft_rdata)
    );

    spfs_ram #(.WIDTH(LW), .DEPTH(PRIME_SLOTS)) u_prime_list (
        .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .raddr(pl_raddr), .rdata(pl_rdata)
    );

    spfs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // Saturate the configured limit
    assign lim_sat = (32'(sieve_limit_reg) > 32'(MAX_LIMIT)) ? LW'(MAX_LIMIT)
                                                            : LW'(sieve_limit_reg);
    assign ft_word = DATA_W'(ft_rdata);
    assign e_dec   = e_reg - NW'(1);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        sieve_limit_next = sieve_limit_reg;
        built_next       = built_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        i_next           = i_reg;
        lim_next         = lim_reg;
        j_next           = j_reg;
        spf_next         = spf_reg;
        p_next           = p_reg;
        m_next           = m_reg;
        cmd_next         = cmd_reg;
        x_next           = x_reg;
        fp_next          = fp_reg;
        n_next           = n_reg;
        e_next           = e_reg;
        chain_next       = chain_reg;
        rv_next          = 1'b0;
        st_next          = st_reg;
        ans_next         = ans_reg;
        last_next        = last_reg;
        ft_we            = 1'b0;
        ft_waddr         = '0;
        ft_wdata         = '0;
        ft_raddr         = '0;
        pl_we            = 1'b0;
        pl_waddr         = '0;
        pl_wdata         = '0;
        pl_raddr         = '0;
        div_req.start    = 1'b0;
        div_req.dividend = x_reg;
        div_req.divisor  = ft_word;

        if (cfg_valid)
        begin
            sieve_limit_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    x_next   = operand;
                    n_next   = '0;
                    ft_raddr = LW'(operand);
                    pl_raddr = PAW'(operand);
                    priority if (command == CMD_BUILD)
                    begin
                        lim_next   = lim_sat;
                        i_next     = '0;
                        count_next = '0;
                        state_next = S_CLEAR;
                    end
                    else if (command == CMD_PRIME)
                    begin
                        if (!valid_reg || 32'(operand) >= 32'(count_reg))
                        begin
                            rv_next = 1'b1; st_next = ST_RANGE;
                            ans_next = '0; last_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_QUERY;
                        end
                    end
                    else if (operand == '0)
                    begin
                        rv_next = 1'b1; st_next = ST_INVALID;
                        ans_next = '0; last_next = 1'b1;
                    end
                    else if (command == CMD_FACT && operand == DATA_W'(1))
                    begin
                        rv_next = 1'b1; st_next = ST_EMPTY;
                        ans_next = '0; last_next = 1'b1;
                    end
                    else if (!valid_reg || 32'(operand) > 32'(built_reg))
                    begin
                        rv_next = 1'b1; st_next = ST_RANGE;
                        ans_next = '0; last_next = 1'b1;
                    end
                    else if (command == CMD_SPF)
                    begin
                        state_next = S_QUERY;
                    end
                    else
                    begin
                        state_next = S_FACT_RD;
                    end
                end
            end

            // Clear 0..lim, seeding one
            S_CLEAR:
            begin
                ft_we    = 1'b1;
                ft_waddr = i_reg[LW-1:0];
                ft_wdata = (i_reg == IW'(1)) ? LW'(1) : '0;
                if (i_reg == IW'(lim_reg))
                begin
                    i_next     = IW'(2);
                    state_next = S_SIEVE_RD;
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                end
            end

            S_SIEVE_RD:
            begin
                ft_raddr = i_reg[LW-1:0];
                state_next = (i_reg > IW'(lim_reg)) ? S_FINISH : S_SIEVE_CHK;
            end

            // Record a new prime or take the known smallest factor
            S_SIEVE_CHK:
            begin
                j_next = '0;
                if (ft_rdata == '0)
                begin
                    if (count_reg == CW'(PRIME_SLOTS))
                    begin
                        lim_next   = LW'(i_reg - IW'(1));
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ft_we      = 1'b1;
                        ft_waddr   = i_reg[LW-1:0];
                        ft_wdata   = i_reg[LW-1:0];
                        pl_we      = 1'b1;
                        pl_waddr   = count_reg[PAW-1:0];
                        pl_wdata   = i_reg[LW-1:0];
                        count_next = count_reg + CW'(1);
                        spf_next   = i_reg[LW-1:0];
                        state_next = S_PRIME_RD;
                    end
                end
                else
                begin
                    spf_next   = ft_rdata;
                    state_next = S_PRIME_RD;
                end
            end

            S_PRIME_RD:
            begin
                pl_raddr = j_reg[PAW-1:0];
                if (j_reg == count_reg)
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_SIEVE_RD;
                end
                else
                begin
                    state_next = S_PRIME_MUL;
                end
            end

            // Form i * p, stop once p passes the smallest factor of i
            S_PRIME_MUL:
            begin
                p_next = pl_rdata;
                m_next = MW'(i_reg[LW-1:0]) * MW'(pl_rdata);
                if (pl_rdata > spf_reg)
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_SIEVE_RD;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end

            S_MARK:
            begin
                if (m_reg > MW'(lim_reg))
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = S_SIEVE_RD;
                end
                else
                begin
                    ft_we      = 1'b1;
                    ft_waddr   = m_reg[LW-1:0];
                    ft_wdata   = p_reg;
                    j_next     = j_reg + CW'(1);
                    state_next = S_PRIME_RD;
                end
            end

            S_FINISH:
            begin
                built_next = lim_reg;
                valid_next = 1'b1;
                rv_next    = 1'b1;
                st_next    = ST_OK;
                ans_next   = DATA_W'(count_reg);
                last_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_QUERY:
            begin
                rv_next    = 1'b1;
                st_next    = ST_OK;
                ans_next   = (cmd_reg == CMD_SPF) ? ft_word : DATA_W'(pl_rdata);
                last_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_FACT_RD:
            begin
                ft_raddr = LW'(x_reg);
                if (x_reg > DATA_W'(1) && n_reg < NW'(FACTOR_CAP))
                begin
                    state_next = S_FACT_CHK;
                end
                else
                begin
                    state_next = S_FACT_END;
                end
            end

            S_FACT_CHK:
            begin
                fp_next = ft_word;
                if (ft_word < DATA_W'(2))
                begin
                    state_next = S_FACT_END;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_FACT_DIV;
                end
            end

            // Push the factor and take the quotient when it divides evenly, else end
            S_FACT_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder != '0)
                    begin
                        state_next = S_FACT_END;
                    end
                    else
                    begin
                        chain_next[n_reg[CIW-1:0]] = fp_reg;
                        n_next     = n_reg + NW'(1);
                        x_next     = div_rsp.quotient;
                        state_next = S_FACT_RD;
                    end
                end
            end

            S_FACT_END:
            begin
                if (n_reg == '0)
                begin
                    rv_next = 1'b1; st_next = ST_EMPTY;
                    ans_next = '0; last_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    e_next     = n_reg;
                    state_next = S_EMIT;
                end
            end

            // Emit the chain from the top down
            S_EMIT:
            begin
                rv_next   = 1'b1;
                st_next   = ST_OK;
                ans_next  = chain_reg[e_dec[CIW-1:0]];
                last_next = (e_reg == NW'(1));
                e_next    = e_dec;
                if (e_reg == NW'(1))
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            sieve_limit_reg <= '0;
            built_reg       <= '0;
            valid_reg       <= 1'b0;
            count_reg       <= '0;
            rv_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sieve_limit_reg <= sieve_limit_next;
            built_reg       <= built_next;
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            rv_reg          <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        lim_reg   <= lim_next;
        j_reg     <= j_next;
        spf_reg   <= spf_next;
        p_reg     <= p_next;
        m_reg     <= m_next;
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        fp_reg    <= fp_next;
        n_reg     <= n_next;
        e_reg     <= e_next;
        chain_reg <= chain_next;
        st_reg    <= st_next;
        ans_reg   <= ans_next;
        last_reg  <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = rv_reg;
    assign status       = st_reg;
    assign answer       = ans_reg;
    assign last         = last_reg;

    // Table marks stay within the build limit
    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK && ft_we) |-> (m_reg <= MW'(lim_reg)))
        else $error("table mark beyond limit");

    // Prime list never overflows
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PRIME_SLOTS))
        else $error("prime count overflow");

    // An accepted build keeps the unit busy
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_BUILD) |=> busy)
        else $error("build did not start");

    // A factor is pushed only while the chain has room
    a_chain_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FACT_DIV && div_rsp.done) |-> (n_reg < NW'(FACTOR_CAP)))
        else $error("factor chain overflow");

endmodule

FILE: sim/smallest_prime_factor_sieve_unit_test.sv
// Self-checking testbench for the smallest-prime-factor sieve unit.
// Depends on spfs_pkg and the unit's RTL; holds its own sieve predictor and result checker.
`timescale 1ns / 100ps

module smallest_prime_factor_sieve_unit_test;
    import spfs_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] operand;
    } query_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   answer;
        logic                last;
    } reply_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    command;
    logic [DATA_W-1:0]   operand;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   answer;
    logic                last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [DATA_W-1:0]   cfg_data;

    // Predictor state
    logic [DATA_W-1:0] spf_table [0:MAX_LIMIT_DEF];
    logic [DATA_W-1:0] primes [0:PRIME_SLOTS_DEF-1];
    int unsigned       num_primes;
    int unsigned       covered_limit;
    bit                sieve_built;
    int unsigned       limit_reg;

    query_t pending_queries[$];
    reply_t expected_replies[$];
    query_t cur_query;
    int     burst_left;
    int     gap_left;
    int     fail_count;
    int     cycle_count;

    smallest_prime_factor_sieve_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .operand      (operand),
        .result_valid (result_valid),
        .status       (status),
        .answer       (answer),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Run the linear sieve over 1..limit
    function automatic void run_sieve();
        int unsigned lim;
        int unsigned i;
        int unsigned j;
        int unsigned p;
        longint unsigned m;
        lim = limit_reg;
        if (lim > MAX_LIMIT_DEF)
            lim = MAX_LIMIT_DEF;
        for (i = 0; i <= lim; i++)
            spf_table[i] = '0;
        num_primes = 0;
        if (lim >= 1)
            spf_table[1] = DATA_W'(1);
        for (i = 2; i <= lim; i++)
        begin
            if (spf_table[i] == 0)
            begin
                if (num_primes >= PRIME_SLOTS_DEF)
                begin
                    lim = i - 1;
                    break;
                end
                spf_table[i] = DATA_W'(i);
                primes[num_primes] = DATA_W'(i);
                num_primes++;
            end
            for (j = 0; j < num_primes; j++)
            begin
                p = primes[j];
                m = longint'(i) * p;
                if (p > spf_table[i] || m > lim)
                    break;
                spf_table[m] = DATA_W'(p);
            end
        end
        covered_limit = lim;
        sieve_built = 1'b1;
    endfunction

    function automatic void push_reply(logic [STATUS_W-1:0] st, int unsigned ans, bit lst);
        reply_t r;
        r.status = st;
        r.answer = ans[DATA_W-1:0];
        r.last   = lst;
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    // Work out the replies of one accepted query
    function automatic void predict_replies(query_t q);
        int unsigned x;
        int unsigned p;
        int unsigned chain[FACTOR_CAP];
        int          n;
        x = q.operand;
        n = 0;
        if (q.command == CMD_BUILD)
        begin
            run_sieve();
            push_reply(ST_OK, num_primes, 1'b1);
        end
        else if (q.command == CMD_PRIME)
        begin
            if (!sieve_built || x >= num_primes)
                push_reply(ST_RANGE, 0, 1'b1);
            else
                push_reply(ST_OK, primes[x], 1'b1);
        end
        else if (x == 0)
            push_reply(ST_INVALID, 0, 1'b1);
        else if (q.command == CMD_FACT && x == 1)
            push_reply(ST_EMPTY, 0, 1'b1);
        else if (!sieve_built || x > covered_limit)
            push_reply(ST_RANGE, 0, 1'b1);
        else if (q.command == CMD_SPF)
            push_reply(ST_OK, spf_table[x], 1'b1);
        else
        begin
            // walk the smallest-factor chain, emit it largest first
            while (x > 1 && n < FACTOR_CAP)
            begin
                p = spf_table[x];
                if (p < 2 || x % p != 0)
                    break;
                chain[n] = p;
                n++;
                x = x / p;
            end
            if (n == 0)
                push_reply(ST_EMPTY, 0, 1'b1);
            for (int k = 0; k < n; k++)
                push_reply(ST_OK, chain[n-1-k], k == n - 1);
        end
    endfunction

    function automatic void add_query(logic [CMD_W-1:0] c, int unsigned v);
        query_t q;
        q.command = c;
        q.operand = v[DATA_W-1:0];
        pending_queries.insert(pending_queries.size(), q);
    endfunction

    // Random query mostly near the built range
    function automatic void add_random_query(bit allow_build);
        logic [CMD_W-1:0] c;
        int unsigned      v;
        int unsigned      hi;
        int               pick;
        c = CMD_W'($urandom_range(allow_build ? 0 : 1, 3));
        pick = $urandom_range(0, 9);
        hi = (c == CMD_PRIME) ? num_primes + 2 : covered_limit + 2;
        if (hi > 65535)
            hi = 65535;
        if (pick < 6)
            v = $urandom_range(0, hi);
        else if (pick < 8)
            v = $urandom_range(0, 65535);
        else
            v = $urandom_range(0, 3);
        add_query(c, v);
    endfunction

    // Hold until every query is accepted and answered
    task automatic wait_idle();
        while (pending_queries.size() != 0 || start || busy || expected_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(int unsigned v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v[DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_reg = v;
        cfg_valid <= 1'b0;
    endtask

    // Driver: present queries in bursts with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_replies(cur_query);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_queries.size() != 0)
                begin
                    cur_query = pending_queries.pop_front();
                    command <= cur_query.command;
                    operand <= cur_query.operand;
                    start   <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        reply_t r;
        if (rst_n && result_valid)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("unexpected result beat: status %0d answer %0d", status, answer);
                fail_count++;
            end
            else
            begin
                r = expected_replies.pop_front();
                if (status !== r.status)
                begin
                    $error("status: expected %0d, actual %0d", r.status, status);
                    fail_count++;
                end
                if (answer !== r.answer)
                begin
                    $error("answer: expected %0d, actual %0d", r.answer, answer);
                    fail_count++;
                end
                if (last !== r.last)
                begin
                    $error("last: expected %0d, actual %0d", r.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_BUILD;
        operand = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        num_primes = 0;
        covered_limit = 0;
        sieve_built = 1'b0;
        limit_reg = 0;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 1;
        gap_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Queries before any build
        add_query(CMD_SPF, 5);
        add_query(CMD_SPF, 1);
        add_query(CMD_FACT, 0);
        add_query(CMD_FACT, 1);
        add_query(CMD_FACT, 12);
        add_query(CMD_PRIME, 0);
        add_query(CMD_SPF, 0);

        // Empty table, then the single entry of one, then the first prime
        write_limit(0);
        add_query(CMD_BUILD, 65535);
        add_query(CMD_SPF, 1);
        add_query(CMD_PRIME, 0);
        write_limit(1);
        add_query(CMD_BUILD, 0);
        add_query(CMD_SPF, 1);
        add_query(CMD_FACT, 1);
        add_query(CMD_SPF, 2);
        write_limit(2);
        add_query(CMD_BUILD, 0);
        add_query(CMD_SPF, 2);
        add_query(CMD_FACT, 2);
        add_query(CMD_PRIME, 0);
        add_query(CMD_PRIME, 1);

        // Small tables with random queries and rebuilds
        write_limit(30);
        add_query(CMD_BUILD, 0);
        wait_idle();
        for (int i = 0; i < 20; i++)
            add_random_query(1'b1);
        write_limit(1000);
        add_query(CMD_BUILD, 0);
        add_query(CMD_FACT, 512);
        add_query(CMD_FACT, 997);
        wait_idle();
        for (int i = 0; i < 30; i++)
            add_random_query(1'b1);

        // Full table: deep factor chains, no further rebuilds
        write_limit(65535);
        add_query(CMD_BUILD, 0);
        add_query(CMD_FACT, 32768);
        add_query(CMD_FACT, 65535);
        add_query(CMD_SPF, 65521);
        add_query(CMD_PRIME, 6541);
        add_query(CMD_PRIME, 6542);
        wait_idle();
        for (int i = 0; i < 30; i++)
            add_random_query(1'b0);

        wait_idle();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
